[hw/rtl/rmf_pkg.sv]
// Shared constants and types for the running median filter.
package rmf_pkg;

  localparam int MAX_HALF_WINDOW_DEF = 127;
  localparam int SAMPLE_WIDTH_DEF    = 16;
  localparam int HALF_WINDOW_RESET   = 75;
  localparam int CFG_WIDTH           = 7;

  // Per-cycle control shared by the sorted cells and the delay line.
  typedef struct packed {
    logic step;     // a word is taken this cycle
    logic restart;  // the word starts a new sequence
    logic wipe;     // the window length is rewritten
  } rmf_ctl_t;

endpackage

[hw/rtl/rmf_cell.sv]
// One position of the sorted window: drop the oldest sample and insert the new one.
module rmf_cell import rmf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rmf_ctl_t                       ctl,
  input  logic                           first,
  input  logic                           last,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic signed [SAMPLE_WIDTH-1:0] gone,
  input  logic signed [SAMPLE_WIDTH-1:0] left_val,
  input  logic                           left_lt,
  input  logic                           left_gt,
  input  logic signed [SAMPLE_WIDTH-1:0] right_val,
  input  logic                           right_gt,
  output logic signed [SAMPLE_WIDTH-1:0] val_eff,
  output logic                           lt_gone,
  output logic                           gt_new,
  output logic signed [SAMPLE_WIDTH-1:0] val_q
);

  logic signed [SAMPLE_WIDTH-1:0] val_r;
  logic signed [SAMPLE_WIDTH-1:0] val_nxt;
  logic                           before_ins;
  logic                           after_ins;

  // A restart makes the window read as zeros for this word.
  assign val_eff = ctl.restart ? '0 : val_r;
  assign lt_gone = val_eff < gone;
  assign gt_new  = val_eff > sample;
  assign val_q   = val_r;

  // Cells left of the removed entry keep their place; those to its right
  // move one place down. The new sample then goes in after every entry
  // that is not greater than it.
  always_comb begin
    before_ins = !last && (lt_gone ? !gt_new : !right_gt);
    after_ins  = !first && (left_lt ? left_gt : gt_new);
    if (before_ins) begin
      val_nxt = lt_gone ? val_eff : right_val;
    end else if (after_ins) begin
      val_nxt = left_lt ? left_val : val_eff;
    end else begin
      val_nxt = sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.wipe) begin
      val_r <= '0;
    end else if (ctl.step) begin
      val_r <= val_nxt;
    end
  end

endmodule

[hw/rtl/rmf_dline.sv]
// Circular delay line that supplies the sample leaving the window.
module rmf_dline import rmf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int DEPTH        = 2 * MAX_HALF_WINDOW_DEF + 1,
  parameter int PW           = $clog2(DEPTH)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rmf_ctl_t                       ctl,
  input  logic [PW-1:0]                  last_idx,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic signed [SAMPLE_WIDTH-1:0] gone
);

  logic signed [SAMPLE_WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0]               vld_r;
  logic [DEPTH-1:0]               vld_nxt;
  logic [PW-1:0]                  ptr_r;
  logic [PW-1:0]                  ptr_nxt;
  logic [PW-1:0]                  ptr_eff;
  logic [PW-1:0]                  ptr_adv;
  logic [PW-1:0]                  rd_addr;
  logic signed [SAMPLE_WIDTH-1:0] rd_r;
  logic                           byp_r;
  logic                           byp_nxt;
  logic signed [SAMPLE_WIDTH-1:0] byp_val_r;
  logic                           zero_r;
  logic                           zero_nxt;

  assign ptr_eff = ctl.restart ? '0 : ptr_r;
  assign ptr_adv = (ptr_eff == last_idx) ? '0 : ptr_eff + 1'b1;
  // The next oldest slot is read ahead so that it is ready for the next word.
  assign rd_addr = ctl.step ? ptr_adv : ptr_r;

  always_comb begin
    vld_nxt  = vld_r;
    ptr_nxt  = ptr_r;
    byp_nxt  = 1'b0;
    zero_nxt = !vld_r[ptr_r];
    if (ctl.wipe) begin
      vld_nxt  = '0;
      ptr_nxt  = '0;
      zero_nxt = 1'b1;
    end else if (ctl.step) begin
      if (ctl.restart) begin
        vld_nxt = '0;
      end
      vld_nxt[ptr_eff] = 1'b1;
      ptr_nxt  = ptr_adv;
      // A one-sample window reads back the slot being written.
      byp_nxt  = (ptr_adv == ptr_eff);
      zero_nxt = ctl.restart || !vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      mem[ptr_eff] <= sample;
    end
    rd_r      <= mem[rd_addr];
    byp_val_r <= sample;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      ptr_r  <= '0;
      byp_r  <= 1'b0;
      zero_r <= 1'b1;
    end else begin
      vld_r  <= vld_nxt;
      ptr_r  <= ptr_nxt;
      byp_r  <= byp_nxt;
      zero_r <= zero_nxt;
    end
  end

  always_comb begin
    if (byp_r) begin
      gone = byp_val_r;
    end else if (zero_r) begin
      gone = '0;
    end else begin
      gone = rd_r;
    end
  end

endmodule

[hw/rtl/running_median_filter_unit.sv]
// Top level of the running median filter: control, sorted cell row and delay line.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall | in_sample, in_restart
//   out     | output    | out_valid/out_stall | out_median
//   cfg     | input     | cfg_wr_en           | cfg_half_window
//
// A word is written into the sorted cell row, then the middle cell is selected
// into the output register; a new word is taken every cycle unless in_stall
// is high. Out_valid rises when a pending median is captured. While the row
// holds a word whose median is not yet captured and the output register is
// full and stalled, in_stall is raised. Reset, and every write of the half
// window, clear the window to zeros at once.
module running_median_filter_unit import rmf_pkg::*; #(
  parameter int MAX_HALF_WINDOW = MAX_HALF_WINDOW_DEF,
  parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_median,
  input  logic                           cfg_wr_en,
  input  logic [CFG_WIDTH-1:0]           cfg_half_window
);

  localparam int DEPTH   = 2 * MAX_HALF_WINDOW + 1;
  localparam int PW      = $clog2(DEPTH);
  localparam int HW      = $clog2(MAX_HALF_WINDOW + 1);
  localparam int H_RESET = (HALF_WINDOW_RESET > MAX_HALF_WINDOW) ?
                           MAX_HALF_WINDOW : HALF_WINDOW_RESET;

  logic [HW-1:0]                  half_r;
  logic [HW-1:0]                  half_nxt;
  logic [PW-1:0]                  last_idx;
  logic                           pend_r;
  logic                           pend_nxt;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] median_r;
  logic signed [SAMPLE_WIDTH-1:0] median_sel;
  logic                           step;
  logic                           capture;
  rmf_ctl_t                       ctl;
  logic signed [SAMPLE_WIDTH-1:0] gone_raw;
  logic signed [SAMPLE_WIDTH-1:0] gone;
  logic signed [SAMPLE_WIDTH-1:0] cell_eff [DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] cell_q   [DEPTH];
  logic                           cell_lt  [DEPTH];
  logic                           cell_gt  [DEPTH];

  // Handshake and the two-stage pipeline.
  assign capture  = pend_r && (!out_valid_r || !out_stall);
  assign in_stall = pend_r && !capture;
  assign step     = in_valid && !in_stall;

  assign ctl.step    = step;
  assign ctl.restart = step && in_restart;
  assign ctl.wipe    = cfg_wr_en;

  assign last_idx = PW'(half_r) << 1;
  assign gone     = ctl.restart ? '0 : gone_raw;

  always_comb begin
    half_nxt = half_r;
    if (cfg_wr_en) begin
      if (32'(cfg_half_window) > MAX_HALF_WINDOW) begin
        half_nxt = HW'(MAX_HALF_WINDOW);
      end else begin
        half_nxt = HW'(cfg_half_window);
      end
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (step) begin
      pend_nxt = 1'b1;
    end else if (capture) begin
      pend_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (capture) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r      <= HW'(H_RESET);
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      half_r      <= half_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The middle cell is picked with a one-hot select over the row.
  always_comb begin
    median_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (PW'(i) == PW'(half_r)) begin
        median_sel = median_sel | cell_q[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      median_r <= median_sel;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_median = median_r;

  rmf_dline #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .DEPTH       (DEPTH),
    .PW          (PW)
  ) u_dline (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .last_idx(last_idx),
    .sample  (in_sample),
    .gone    (gone_raw)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] left_val;
    logic                           left_lt;
    logic                           left_gt;
    logic signed [SAMPLE_WIDTH-1:0] right_val;
    logic                           right_gt;

    if (g == 0) begin : g_head
      assign left_val = '0;
      assign left_lt  = 1'b0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_val = cell_eff[g-1];
      assign left_lt  = cell_lt[g-1];
      assign left_gt  = cell_gt[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_val = '0;
      assign right_gt  = 1'b0;
    end else begin : g_body
      assign right_val = cell_eff[g+1];
      assign right_gt  = cell_gt[g+1];
    end

    rmf_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .first    (g == 0),
      .last     (last_idx == PW'(g)),
      .sample   (in_sample),
      .gone     (gone),
      .left_val (left_val),
      .left_lt  (left_lt),
      .left_gt  (left_gt),
      .right_val(right_val),
      .right_gt (right_gt),
      .val_eff  (cell_eff[g]),
      .lt_gone  (cell_lt[g]),
      .gt_new   (cell_gt[g]),
      .val_q    (cell_q[g])
    );
  end

`ifndef SYNTHESIS
  a_word_pends: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> pend_r)
    else $error("accepted word left no pending median");

  a_out_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pend_r))
    else $error("result raised without a pending median");

  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && out_valid_r && out_stall) |-> in_stall)
    else $error("input taken while a median is still waiting");

  a_half_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(half_r) <= MAX_HALF_WINDOW)
    else $error("half window beyond its maximum");
`endif

endmodule
